FILE: rtl/core/lcsb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_pkg
// Shared types and constants of the LED cube subframe buffer.
// ----------------------------------------------------------------------------
package lcsb_pkg;

    localparam int CUBE_SIDE_DEF = 8;
    localparam int SUBFRAMES_DEF = 3;

    localparam int COORD_W     = 3;
    localparam int LEVEL_W     = 2;
    localparam int ROW_INDEX_W = 6;
    localparam int COLOR_W     = 8;
    localparam int WORD_W      = 3 * COLOR_W;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_READ  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_LOAD
    } state_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } levels_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        levels_t            levels;
    } merge_req_t;

endpackage

FILE: rtl/core/lcsb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_if
// Request and response channels of the LED cube subframe buffer.
// ----------------------------------------------------------------------------
interface lcsb_req_if import lcsb_pkg::*; ();

    logic                   valid;
    logic                   ready;
    cmd_t                   cmd;
    logic [COORD_W-1:0]     x;
    logic [COORD_W-1:0]     y;
    logic [COORD_W-1:0]     z;
    logic [LEVEL_W-1:0]     red_level;
    logic [LEVEL_W-1:0]     green_level;
    logic [LEVEL_W-1:0]     blue_level;
    logic [ROW_INDEX_W-1:0] row_index;

    modport source (
        output valid, cmd, x, y, z, red_level, green_level, blue_level, row_index,
        input  ready
    );

    modport sink (
        input  valid, cmd, x, y, z, red_level, green_level, blue_level, row_index,
        output ready
    );

    modport monitor (
        input valid, ready, cmd, x, y, z, red_level, green_level, blue_level, row_index
    );

endinterface

interface lcsb_rsp_if import lcsb_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_bits;
    logic [COLOR_W-1:0] green_bits;
    logic [COLOR_W-1:0] blue_bits;

    modport source (
        output valid, red_bits, green_bits, blue_bits,
        input  ready
    );

    modport sink (
        input  valid, red_bits, green_bits, blue_bits,
        output ready
    );

    modport monitor (
        input valid, ready, red_bits, green_bits, blue_bits
    );

endinterface

FILE: rtl/core/lcsb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcsb_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/lcsb_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_merge
// Shared compare and bit-merge unit: places one voxel's subframe bits
// into a stored row word, one subframe per use.
// ----------------------------------------------------------------------------
module lcsb_merge import lcsb_pkg::*; #(
    parameter int SUB_W = 2
) (
    input  logic [WORD_W-1:0] old_word,
    input  logic [SUB_W-1:0]  sub,
    input  merge_req_t        req,
    output logic [WORD_W-1:0] new_word
);

    logic               red_on;
    logic               green_on;
    logic               blue_on;
    logic [COLOR_W-1:0] mask;

    // thermometer code bit k of level L is set when k < L
    assign red_on   = 3'(sub) < 3'(req.levels.red);
    assign green_on = 3'(sub) < 3'(req.levels.green);
    assign blue_on  = 3'(sub) < 3'(req.levels.blue);
    assign mask     = COLOR_W'(1) << req.x;

    always_comb
    begin
        new_word[COLOR_W-1:0] = (old_word[COLOR_W-1:0] & ~mask)
                              | (COLOR_W'(red_on) << req.x);
        new_word[2*COLOR_W-1:COLOR_W] = (old_word[2*COLOR_W-1:COLOR_W] & ~mask)
                                      | (COLOR_W'(green_on) << req.x);
        new_word[3*COLOR_W-1:2*COLOR_W] = (old_word[3*COLOR_W-1:2*COLOR_W] & ~mask)
                                        | (COLOR_W'(blue_on) << req.x);
    end

endmodule

FILE: rtl/core/lcsb_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_ctrl
// Sequencer of the subframe buffer: takes items, walks the subframes of a
// row through the merge unit, tracks written rows and holds the result.
// ----------------------------------------------------------------------------
module lcsb_ctrl import lcsb_pkg::*; #(
    parameter  int CUBE_SIDE = CUBE_SIDE_DEF,
    parameter  int SUBFRAMES = SUBFRAMES_DEF,
    localparam int ROWS      = CUBE_SIDE * CUBE_SIDE,
    localparam int RW        = $clog2(ROWS),
    localparam int SUB_W     = (SUBFRAMES > 1) ? $clog2(SUBFRAMES) : 1,
    localparam int DEPTH     = SUBFRAMES * (2 ** RW),
    localparam int MAW       = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    lcsb_req_if.sink          req,
    lcsb_rsp_if.source        rsp,
    output logic              ram_we,
    output logic              ram_re,
    output logic [MAW-1:0]    ram_addr,
    input  logic [WORD_W-1:0] ram_rdata,
    output logic [WORD_W-1:0] merge_old,
    output logic [SUB_W-1:0]  merge_sub,
    output merge_req_t        merge_req,
    input  logic [WORD_W-1:0] merge_word
);

    state_t             state_reg,     state_next;
    cmd_t               cmd_reg,       cmd_next;
    logic [SUB_W-1:0]   sub_reg,       sub_next;
    logic [SUB_W-1:0]   counter_reg,   counter_next;
    logic [RW-1:0]      row_reg,       row_next;
    logic               row_ok_reg,    row_ok_next;
    merge_req_t         mreq_reg,      mreq_next;
    logic [2**RW-1:0]   valid_reg,     valid_next;
    logic               out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]  out_word_reg,  out_word_next;

    logic [ROW_INDEX_W-1:0] row_calc;
    logic                   voxel_ok;
    logic                   accept;
    logic                   row_written;
    logic [SUB_W+RW-1:0]    addr_full;

    assign row_calc = ROW_INDEX_W'(req.z) * ROW_INDEX_W'(CUBE_SIDE) + ROW_INDEX_W'(req.y);
    assign voxel_ok = ({1'b0, req.x} < 4'(CUBE_SIDE))
                   && ({1'b0, req.y} < 4'(CUBE_SIDE))
                   && ({1'b0, req.z} < 4'(CUBE_SIDE));
    assign accept      = req.valid && req.ready;
    assign row_written = valid_reg[row_reg];
    assign addr_full   = {sub_reg, row_reg};

    assign req.ready      = (state_reg == S_IDLE);
    assign ram_addr       = addr_full[MAW-1:0];
    assign merge_old      = row_written ? ram_rdata : '0;
    assign merge_sub      = sub_reg;
    assign merge_req      = mreq_reg;
    assign rsp.valid      = out_valid_reg;
    assign rsp.red_bits   = out_word_reg[COLOR_W-1:0];
    assign rsp.green_bits = out_word_reg[2*COLOR_W-1:COLOR_W];
    assign rsp.blue_bits  = out_word_reg[3*COLOR_W-1:2*COLOR_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_WRITE;
            sub_reg       <= '0;
            counter_reg   <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            sub_reg       <= sub_next;
            counter_reg   <= counter_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg      <= row_next;
        row_ok_reg   <= row_ok_next;
        mreq_reg     <= mreq_next;
        out_word_reg <= out_word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        sub_next       = sub_reg;
        counter_next   = counter_reg;
        row_next       = row_reg;
        row_ok_next    = row_ok_reg;
        mreq_next      = mreq_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = req.cmd;
                    if (req.cmd == CMD_READ)
                    begin
                        row_next    = req.row_index[RW-1:0];
                        row_ok_next = {1'b0, req.row_index} < (ROW_INDEX_W+1)'(ROWS);
                        sub_next    = counter_reg;
                        state_next  = S_RD;
                    end
                    else if (voxel_ok)
                    begin
                        row_next              = row_calc[RW-1:0];
                        sub_next              = '0;
                        mreq_next.x           = req.x;
                        mreq_next.levels.red   = req.red_level;
                        mreq_next.levels.green = req.green_level;
                        mreq_next.levels.blue  = req.blue_level;
                        state_next            = S_RD;
                    end
                end
            end
            S_RD:
            begin
                ram_re     = 1'b1;
                state_next = (cmd_reg == CMD_READ) ? S_LOAD : S_WR;
            end
            S_WR:
            begin
                ram_we = 1'b1;
                if (sub_reg == SUB_W'(SUBFRAMES - 1))
                begin
                    valid_next[row_reg] = 1'b1;
                    state_next          = S_IDLE;
                end
                else
                begin
                    sub_next   = sub_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_LOAD:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = (row_ok_reg && row_written) ? ram_rdata : '0;
                    counter_next   = (counter_reg == SUB_W'(SUBFRAMES - 1))
                                   ? '0 : counter_reg + 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/led_cube_subframe_buffer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_cube_subframe_buffer_unit
// Bit-plane frame buffer of an RGB LED cube, one row word per subframe.
// ----------------------------------------------------------------------------
// Channels: req carries a voxel write (cmd = write: x, y, z and three
// colour levels) or a row read (cmd = read: row_index). rsp carries the
// red, green and blue bytes of the read row in the current subframe; a
// write gives no rsp item, and each read advances the subframe counter.
// Timing: one item at a time. A write runs a read and a write of the
// row's word for each subframe through one merge unit, and req stays busy
// until the last subframe's word is written; a write outside the cube is
// dropped and req is ready the next cycle. A read puts its item on rsp
// through the registered RAM read and then the output register, and req
// is ready again once the item is in the output register.
// Reset clears the counter and marks every row unwritten, so all rows
// read as zero at once with no clearing pass.
// Stall: while rsp holds an untaken item, writes go on; a following read
// waits with its data in the RAM output register and holds req busy until
// rsp takes the older item.
// ----------------------------------------------------------------------------
module led_cube_subframe_buffer_unit import lcsb_pkg::*; #(
    parameter int CUBE_SIDE = CUBE_SIDE_DEF,
    parameter int SUBFRAMES = SUBFRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lcsb_req_if.sink    req,
    lcsb_rsp_if.source  rsp
);

    localparam int ROWS  = CUBE_SIDE * CUBE_SIDE;
    localparam int RW    = $clog2(ROWS);
    localparam int SUB_W = (SUBFRAMES > 1) ? $clog2(SUBFRAMES) : 1;
    localparam int DEPTH = SUBFRAMES * (2 ** RW);
    localparam int MAW   = $clog2(DEPTH);

    logic              ram_we;
    logic              ram_re;
    logic [MAW-1:0]    ram_addr;
    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] merge_old;
    logic [SUB_W-1:0]  merge_sub;
    merge_req_t        merge_req;
    logic [WORD_W-1:0] merge_word;

    lcsb_ctrl #(
        .CUBE_SIDE (CUBE_SIDE),
        .SUBFRAMES (SUBFRAMES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .ram_we     (ram_we),
        .ram_re     (ram_re),
        .ram_addr   (ram_addr),
        .ram_rdata  (ram_rdata),
        .merge_old  (merge_old),
        .merge_sub  (merge_sub),
        .merge_req  (merge_req),
        .merge_word (merge_word)
    );

    lcsb_merge #(
        .SUB_W (SUB_W)
    ) u_merge (
        .old_word (merge_old),
        .sub      (merge_sub),
        .req      (merge_req),
        .new_word (merge_word)
    );

    lcsb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (merge_word),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

endmodule

FILE: rtl/core/lcsb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsb_checker
// Port-level checks of the subframe buffer, bound to the top level.
// ----------------------------------------------------------------------------
module lcsb_checker import lcsb_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input cmd_t req_cmd,
    input logic rsp_valid,
    input logic rsp_ready
);

    logic req_accept;
    logic is_read;

    assign req_accept = req_valid && req_ready;
    assign is_read    = (req_cmd == CMD_READ);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("rsp item dropped while stalled");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("rsp valid during reset");

    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && is_read |=> !req_ready)
        else $error("req ready right after a read item");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && !is_read && !rsp_valid |=> !rsp_valid)
        else $error("write item produced a rsp item");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && is_read && !rsp_valid |-> ##3 rsp_valid)
        else $error("read item not answered in three cycles");

endmodule

bind led_cube_subframe_buffer_unit lcsb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_cmd   (req.cmd),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready)
);
